/* rtl/mvw_pkg.sv */
// mesh vertex weld package: word types, field widths, command and error codes
// shared by the top level and the scan unit; depends on nothing
package mvw_pkg;

  localparam int CoordW  = 24;
  localparam int IndexW  = 10;
  localparam int TotalW  = 11;
  localparam int DistW   = 52;
  localparam int CmdW    = 2;
  localparam int ErrW    = 2;
  localparam int VertexW = 3 * CoordW;

  localparam logic [DistW-1:0] WeldDistSqRst = 52'd17;

  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CmdW-1:0] CMD_VERTEX = 2'd1;
  localparam logic [CmdW-1:0] CMD_FACE   = 2'd2;

  localparam logic [ErrW-1:0] ERR_OK       = 2'd0;
  localparam logic [ErrW-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ErrW-1:0] ERR_UNKNOWN  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [IndexW-1:0]        corner_a;
    logic [IndexW-1:0]        corner_b;
    logic [IndexW-1:0]        corner_c;
    logic                     last_item;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0] weld_index;
    logic              is_new;
    logic [IndexW-1:0] new_a;
    logic [IndexW-1:0] new_b;
    logic [IndexW-1:0] new_c;
    logic              face_legal;
    logic [TotalW-1:0] unique_total;
    logic [ErrW-1:0]   error_code;
    logic              last_out;
  } out_word_t;

  // control from the sequencer into the scan unit
  typedef struct packed {
    logic start;
    logic store;
  } scan_req_t;

  // status from the scan unit, done is a one-cycle pulse
  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

/* rtl/mvw_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/mvw_scan.sv */
// vertex store and distance scan: walks the unique vertices one per cycle
// through a three-stage read / square / sum-compare pipe; uses mvw_pkg, mvw_ram
module mvw_scan #(
  parameter int MaxVerts = 1024,
  parameter int IdxW     = $clog2(MaxVerts),
  parameter int CntW     = $clog2(MaxVerts + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mvw_pkg::scan_req_t             req_i,
  input  logic [mvw_pkg::VertexW-1:0]    vertex_i,
  input  logic [CntW-1:0]                limit_i,
  input  logic [mvw_pkg::DistW-1:0]      thresh_i,
  input  logic [IdxW-1:0]                wr_addr_i,
  output mvw_pkg::scan_rsp_t             rsp_o,
  output logic [IdxW-1:0]                hit_idx_o
);

  localparam int CW  = mvw_pkg::CoordW;
  localparam int DW  = CW + 1;
  localparam int SqW = 2 * DW;
  localparam int SumW = SqW + 1;
  localparam int DistW = mvw_pkg::DistW;

  logic                  active_q;
  logic [CntW-1:0]       rd_addr_q;
  logic                  s1_vld_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic                  s2_vld_q;
  logic [IdxW-1:0]       s2_idx_q;
  logic [SqW-1:0]        sq_x_q, sq_y_q, sq_z_q;

  logic [mvw_pkg::VertexW-1:0] rd_data;
  logic                  more;
  logic                  rd_en;
  logic                  hit_now;
  logic                  done;
  logic [SumW-1:0]       dist_sum;
  logic signed [CW-1:0]  vx, vy, vz, sx, sy, sz;
  logic signed [DW-1:0]  dx, dy, dz;
  logic [DW-1:0]         mx, my, mz;

  mvw_ram #(
    .WIDTH (mvw_pkg::VertexW),
    .DEPTH (MaxVerts)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (req_i.store),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (vertex_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  assign vx = vertex_i[3*CW-1:2*CW];
  assign vy = vertex_i[2*CW-1:CW];
  assign vz = vertex_i[CW-1:0];
  assign sx = rd_data[3*CW-1:2*CW];
  assign sy = rd_data[2*CW-1:CW];
  assign sz = rd_data[CW-1:0];

  // stage 2 inputs: exact differences and their magnitudes
  always_comb begin
    dx = DW'(vx) - DW'(sx);
    dy = DW'(vy) - DW'(sy);
    dz = DW'(vz) - DW'(sz);
    mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    my = dy[DW-1] ? DW'(-dy) : DW'(dy);
    mz = dz[DW-1] ? DW'(-dz) : DW'(dz);
  end

  // stage 3: sum of squares against the threshold
  assign dist_sum = SumW'(sq_x_q) + SumW'(sq_y_q) + SumW'(sq_z_q);
  assign hit_now  = s2_vld_q && (DistW'(dist_sum) < thresh_i);
  assign more     = rd_addr_q < limit_i;
  assign rd_en    = active_q && more && !hit_now;
  assign done     = active_q && (hit_now || (!more && !s1_vld_q && !s2_vld_q));

  assign rsp_o.done = done;
  assign rsp_o.hit  = hit_now;
  assign hit_idx_o  = s2_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rd_addr_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else if (req_i.start) begin
      active_q  <= 1'b1;
      rd_addr_q <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
    end else begin
      if (done) begin
        active_q <= 1'b0;
      end
      if (rd_en) begin
        rd_addr_q <= rd_addr_q + CntW'(1);
      end
      // first hit wins, later entries in flight are dropped
      s1_vld_q <= rd_en;
      s2_vld_q <= s1_vld_q && !hit_now;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_addr_q[IdxW-1:0];
    s2_idx_q <= s1_idx_q;
    sq_x_q   <= mx * mx;
    sq_y_q   <= my * my;
    sq_z_q   <= mz * mz;
  end

endmodule

/* rtl/mesh_vertex_weld_and_face_cull_unit.sv */
// mesh vertex weld and face cull top level: sequencer, counters, index map
// depends on mvw_pkg, mvw_ram and mvw_scan
//
// Takes one word at a time and returns exactly one result word per input word.
// A clear word resets the unique and seen counts. A vertex word is compared in
// order against the stored unique vertices, one entry per cycle through the
// single read port of the vertex store, and is welded to the first one whose
// squared distance is strictly below weld_dist_sq (unsigned squared coordinate
// units, reset 17), or else stored as a new unique vertex; its original-to-unique
// mapping goes into the index map. A face word reads its three corners from the
// index map one per cycle. Results sit in an output register, so the next word
// is taken while a finished result still waits. Overflow (seen count already at
// MAX_VERTS) gives error 1, and a face corner not yet seen gives error 2. The
// stores have no reset and need no clearing pass.
module mesh_vertex_weld_and_face_cull_unit #(
  parameter int MAX_VERTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mvw_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mvw_pkg::out_word_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mvw_pkg::DistW-1:0]   cfg_data_i
);

  localparam int IdxW    = $clog2(MAX_VERTS);
  localparam int CntW    = $clog2(MAX_VERTS + 1);
  localparam int IdxOutW = mvw_pkg::IndexW;
  localparam int TotW    = mvw_pkg::TotalW;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FACE = 3'd3;
  localparam logic [2:0] ST_FEND = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // face corner step: three reads, then the last capture
  localparam logic [1:0] FACE_K_LAST = 2'd3;

  logic [2:0]                  state_q, state_d;
  mvw_pkg::in_word_t           item_q;
  mvw_pkg::out_word_t          pend_q, pend_d;
  mvw_pkg::out_word_t          out_q;
  logic                        out_vld_q;
  logic [CntW-1:0]             unique_cnt_q, unique_cnt_d;
  logic [CntW-1:0]             seen_cnt_q, seen_cnt_d;
  logic [mvw_pkg::DistW-1:0]   thresh_q;
  logic [1:0]                  face_k_q;
  logic [IdxW-1:0]             map_q [3];

  mvw_pkg::scan_req_t          scan_req;
  mvw_pkg::scan_rsp_t          scan_rsp;
  logic [IdxW-1:0]             hit_idx;
  logic [IdxW-1:0]             weld_sel;
  logic                        seen_full;
  logic                        out_load;
  logic                        store_wr;
  logic                        map_wr;
  logic                        map_rd_en;
  logic [IdxW-1:0]             map_rd_addr;
  logic [IdxW-1:0]             map_rd_data;
  logic [IdxOutW-1:0]          corner [3];
  logic [2:0]                  known;
  logic                        prev_known;
  logic                        all_known;
  logic                        legal;

  // a corner is known once its original index has been seen since the clear
  assign corner[0] = item_q.corner_a;
  assign corner[1] = item_q.corner_b;
  assign corner[2] = item_q.corner_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      known[k] = (32'(corner[k]) < 32'(seen_cnt_q)) && (32'(corner[k]) < MAX_VERTS);
    end
  end

  assign seen_full = seen_cnt_q == CntW'(MAX_VERTS);
  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  // a miss takes the next free slot, which exists since unique <= seen < max
  assign weld_sel = scan_rsp.hit ? hit_idx : unique_cnt_q[IdxW-1:0];

  // face corners are read from the index map one per step, captured a step later
  always_comb begin
    map_rd_en   = 1'b0;
    map_rd_addr = '0;
    prev_known  = known[2];
    case (face_k_q)
      2'd0: begin
        map_rd_addr = IdxW'(corner[0]);
        map_rd_en   = (state_q == ST_FACE) && known[0];
      end
      2'd1: begin
        map_rd_addr = IdxW'(corner[1]);
        map_rd_en   = (state_q == ST_FACE) && known[1];
        prev_known  = known[0];
      end
      2'd2: begin
        map_rd_addr = IdxW'(corner[2]);
        map_rd_en   = (state_q == ST_FACE) && known[2];
        prev_known  = known[1];
      end
      default: begin
        prev_known  = known[2];
      end
    endcase
  end

  assign all_known = &known;
  assign legal     = all_known && (map_q[0] != map_q[1]) && (map_q[1] != map_q[2]) &&
                     (map_q[2] != map_q[0]);

  // sequencer and counters
  always_comb begin
    state_d      = state_q;
    unique_cnt_d = unique_cnt_q;
    seen_cnt_d   = seen_cnt_q;
    scan_req     = '0;
    store_wr     = 1'b0;
    map_wr       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (item_q.cmd)
          mvw_pkg::CMD_CLEAR: begin
            unique_cnt_d = '0;
            seen_cnt_d   = '0;
            state_d      = ST_DONE;
          end
          mvw_pkg::CMD_VERTEX: begin
            if (seen_full) begin
              state_d = ST_DONE;
            end else begin
              scan_req.start = 1'b1;
              state_d        = ST_SCAN;
            end
          end
          mvw_pkg::CMD_FACE: begin
            state_d = ST_FACE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          map_wr     = 1'b1;
          store_wr   = !scan_rsp.hit;
          seen_cnt_d = seen_cnt_q + CntW'(1);
          if (!scan_rsp.hit) begin
            unique_cnt_d = unique_cnt_q + CntW'(1);
          end
          state_d = ST_DONE;
        end
      end
      ST_FACE: begin
        if (face_k_q == FACE_K_LAST) begin
          state_d = ST_FEND;
        end
      end
      ST_FEND: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    scan_req.store = store_wr;
  end

  // result word being built for the current input word
  always_comb begin
    pend_d = pend_q;
    if (state_q == ST_EXEC) begin
      pend_d              = '0;
      pend_d.last_out     = item_q.last_item;
      pend_d.unique_total = (item_q.cmd == mvw_pkg::CMD_CLEAR) ? '0 : TotW'(unique_cnt_q);
      pend_d.error_code   = (item_q.cmd == mvw_pkg::CMD_VERTEX && seen_full) ?
                            mvw_pkg::ERR_OVERFLOW : mvw_pkg::ERR_OK;
    end
    if (state_q == ST_SCAN && scan_rsp.done) begin
      pend_d.weld_index   = IdxOutW'(weld_sel);
      pend_d.is_new       = !scan_rsp.hit;
      pend_d.unique_total = TotW'(unique_cnt_d);
    end
    if (state_q == ST_FEND) begin
      pend_d.new_a      = IdxOutW'(map_q[0]);
      pend_d.new_b      = IdxOutW'(map_q[1]);
      pend_d.new_c      = IdxOutW'(map_q[2]);
      pend_d.face_legal = legal;
      pend_d.error_code = all_known ? mvw_pkg::ERR_OK : mvw_pkg::ERR_UNKNOWN;
    end
  end

  mvw_scan #(
    .MaxVerts (MAX_VERTS),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (scan_req),
    .vertex_i  ({item_q.pos_x, item_q.pos_y, item_q.pos_z}),
    .limit_i   (unique_cnt_q),
    .thresh_i  (thresh_q),
    .wr_addr_i (unique_cnt_q[IdxW-1:0]),
    .rsp_o     (scan_rsp),
    .hit_idx_o (hit_idx)
  );

  // original vertex index to unique index
  mvw_ram #(
    .WIDTH (IdxW),
    .DEPTH (MAX_VERTS)
  ) u_index_map (
    .clk_i     (clk_i),
    .wr_en_i   (map_wr),
    .wr_addr_i (seen_cnt_q[IdxW-1:0]),
    .wr_data_i (weld_sel),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (map_rd_addr),
    .rd_data_o (map_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      unique_cnt_q <= '0;
      seen_cnt_q   <= '0;
      thresh_q     <= mvw_pkg::WeldDistSqRst;
      out_vld_q    <= 1'b0;
      face_k_q     <= '0;
    end else begin
      state_q      <= state_d;
      unique_cnt_q <= unique_cnt_d;
      seen_cnt_q   <= seen_cnt_d;
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == ST_EXEC) begin
        face_k_q <= '0;
      end else if (state_q == ST_FACE) begin
        face_k_q <= face_k_q + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    pend_q <= pend_d;
    if (state_q == ST_FACE && face_k_q != 2'd0) begin
      case (face_k_q)
        2'd1:    map_q[0] <= prev_known ? map_rd_data : '0;
        2'd2:    map_q[1] <= prev_known ? map_rd_data : '0;
        default: map_q[2] <= prev_known ? map_rd_data : '0;
      endcase
    end
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTH
  a_unique_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unique_cnt_q <= seen_cnt_q)
    else $error("unique count ran ahead of seen count");

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(seen_cnt_q) <= MAX_VERTS)
    else $error("seen count beyond store depth");

  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> state_q == ST_SCAN)
    else $error("scan finished outside the scan state");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr |-> !seen_full && (unique_cnt_q <= seen_cnt_q))
    else $error("new vertex stored without room");

  a_pend_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_load) |=> state_q == ST_DONE)
    else $error("pending result left before being loaded");
`endif

endmodule

/* test/mesh_vertex_weld_and_face_cull_unit_tb.sv */
`timescale 1ns / 100ps
// testbench for mesh_vertex_weld_and_face_cull_unit: directed and random vertex, face,
// clear and weld threshold traffic, each result checked against a built-in weld model
// depends on mvw_pkg and the unit rtl

module mesh_vertex_weld_and_face_cull_unit_tb;

  localparam int CoordW = mvw_pkg::CoordW;
  localparam int IndexW = mvw_pkg::IndexW;
  localparam int TotalW = mvw_pkg::TotalW;
  localparam int DistW  = mvw_pkg::DistW;
  localparam int CmdW   = mvw_pkg::CmdW;
  typedef mvw_pkg::in_word_t  in_word_t;
  typedef mvw_pkg::out_word_t out_word_t;

  localparam int MaxVerts = 1024;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned FreshFill = 50;
  localparam int unsigned FillTarget = 70;
  localparam longint unsigned CycleLimit = 64'd6_000_000;
  localparam logic [CmdW-1:0] CmdUnknown = 2'd3;
  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // weld model: unique store, original-to-unique map, counts and threshold,
  // plus the queue of result words still due from the unit
  class weld_tracker #(int Depth = 1024);
    logic signed [CoordW-1:0] sx [Depth];
    logic signed [CoordW-1:0] sy [Depth];
    logic signed [CoordW-1:0] sz [Depth];
    logic [IndexW-1:0] wmap [Depth];
    int unsigned unique_cnt;
    int unsigned seen_cnt;
    logic [DistW-1:0] thr;
    out_word_t due [$];
    int unsigned fail_count;

    function new();
      unique_cnt = 0;
      seen_cnt = 0;
      thr = mvw_pkg::WeldDistSqRst;
      fail_count = 0;
    endfunction

    function longint unsigned sq_gap(logic signed [CoordW-1:0] a, logic signed [CoordW-1:0] b);
      longint t;
      t = longint'(a) - longint'(b);
      if (t < 0) t = -t;
      return $unsigned(t) * $unsigned(t);
    endfunction

    function out_word_t weld_predict(in_word_t w);
      out_word_t r;
      logic [IndexW-1:0] c [3];
      logic [IndexW-1:0] m [3];
      longint unsigned d;
      int unsigned hit;
      bit found;
      bit known;
      r = '0;
      r.last_out = w.last_item;
      case (w.cmd)
        mvw_pkg::CMD_CLEAR: begin
          unique_cnt = 0;
          seen_cnt = 0;
        end
        mvw_pkg::CMD_VERTEX: begin
          if (seen_cnt >= Depth) begin
            r.error_code = mvw_pkg::ERR_OVERFLOW;
          end else begin
            hit = unique_cnt;
            found = 1'b0;
            // first stored unique vertex strictly inside the threshold wins
            for (int j = 0; j < unique_cnt && !found; j++) begin
              d = sq_gap(w.pos_x, sx[j]) + sq_gap(w.pos_y, sy[j]) + sq_gap(w.pos_z, sz[j]);
              if (d < thr) begin
                hit = j;
                found = 1'b1;
              end
            end
            if (!found) begin
              sx[hit] = w.pos_x;
              sy[hit] = w.pos_y;
              sz[hit] = w.pos_z;
              unique_cnt++;
              r.is_new = 1'b1;
            end
            wmap[seen_cnt] = IndexW'(hit);
            seen_cnt++;
            r.weld_index = IndexW'(hit);
          end
        end
        mvw_pkg::CMD_FACE: begin
          c[0] = w.corner_a;
          c[1] = w.corner_b;
          c[2] = w.corner_c;
          known = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (c[k] < seen_cnt) begin
              m[k] = wmap[c[k]];
            end else begin
              m[k] = '0;
              known = 1'b0;
            end
          end
          r.new_a = m[0];
          r.new_b = m[1];
          r.new_c = m[2];
          if (!known) r.error_code = mvw_pkg::ERR_UNKNOWN;
          else if (m[0] != m[1] && m[1] != m[2] && m[2] != m[0]) r.face_legal = 1'b1;
        end
        default: ;
      endcase
      r.unique_total = TotalW'(unique_cnt);
      return r;
    endfunction

    function void note_word(in_word_t w);
      due.push_back(weld_predict(w));
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      string bad;
      if (due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result word with nothing due: %p", got);
        return;
      end
      e = due.pop_front();
      bad = "";
      if (got.weld_index !== e.weld_index) bad = {bad, " weld_index"};
      if (got.is_new !== e.is_new) bad = {bad, " is_new"};
      if (got.new_a !== e.new_a) bad = {bad, " new_a"};
      if (got.new_b !== e.new_b) bad = {bad, " new_b"};
      if (got.new_c !== e.new_c) bad = {bad, " new_c"};
      if (got.face_legal !== e.face_legal) bad = {bad, " face_legal"};
      if (got.unique_total !== e.unique_total) bad = {bad, " unique_total"};
      if (got.error_code !== e.error_code) bad = {bad, " error_code"};
      if (got.last_out !== e.last_out) bad = {bad, " last_out"};
      if (bad != "") begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch in%s: expected %p, got %p", bad, e, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_word_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_word_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [DistW-1:0] cfg_data_i;

  weld_tracker #(MaxVerts) tracker;
  bit no_idle;
  int unsigned stall_left = 0;
  longint unsigned cycle_count = 0;
  int unsigned sent_seen;
  int unsigned random_done;
  // coordinates sent since the last clear, source of near and exact repeats
  logic signed [CoordW-1:0] px [MaxVerts];
  logic signed [CoordW-1:0] py [MaxVerts];
  logic signed [CoordW-1:0] pz [MaxVerts];
  int unsigned n_sent;

  mesh_vertex_weld_and_face_cull_unit #(
    .MAX_VERTS(MaxVerts)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_ni && !no_idle && $urandom_range(0, 99) < 20) begin
      out_stall_i <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // a result word moves when valid is high and stall is low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_word(out_data_o);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // unused fields carry random bits so every input bit toggles
  function automatic in_word_t noise_word();
    logic [127:0] t;
    t = {$urandom, $urandom, $urandom, $urandom};
    return in_word_t'(t[$bits(in_word_t)-1:0]);
  endfunction

  function automatic in_word_t vtx(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                                   logic signed [CoordW-1:0] z, logic last);
    in_word_t w;
    w = noise_word();
    w.cmd = mvw_pkg::CMD_VERTEX;
    w.pos_x = x;
    w.pos_y = y;
    w.pos_z = z;
    w.last_item = last;
    return w;
  endfunction

  function automatic in_word_t face(logic [IndexW-1:0] a, logic [IndexW-1:0] b,
                                    logic [IndexW-1:0] c, logic last);
    in_word_t w;
    w = noise_word();
    w.cmd = mvw_pkg::CMD_FACE;
    w.corner_a = a;
    w.corner_b = b;
    w.corner_c = c;
    w.last_item = last;
    return w;
  endfunction

  function automatic in_word_t ctl(logic [CmdW-1:0] cmd, logic last);
    in_word_t w;
    w = noise_word();
    w.cmd = cmd;
    w.last_item = last;
    return w;
  endfunction

  function automatic logic signed [CoordW-1:0] nudge(logic signed [CoordW-1:0] v,
                                                     int unsigned amp);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * amp)) - int'(amp);
    return t[CoordW-1:0];
  endfunction

  function automatic logic [IndexW-1:0] pick_corner();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sent_seen == 0 || r < 8) return IndexW'($urandom_range(0, MaxVerts - 1));
    if (r < 12 && sent_seen < MaxVerts) return IndexW'(sent_seen);
    return IndexW'($urandom_range(0, sent_seen - 1));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (w.cmd == mvw_pkg::CMD_CLEAR) begin
      sent_seen = 0;
      n_sent = 0;
    end else if (w.cmd == mvw_pkg::CMD_VERTEX && sent_seen < MaxVerts) begin
      sent_seen++;
      px[n_sent] = w.pos_x;
      py[n_sent] = w.pos_y;
      pz[n_sent] = w.pos_z;
      n_sent++;
    end
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (tracker.due.size() != 0) @(negedge clk_i);
  endtask

  // threshold write, only ever issued with the unit idle
  task automatic write_threshold(input logic [DistW-1:0] v);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.thr = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // one mesh: optional threshold write and clear, a run of vertices, then faces over them
  task automatic run_phase();
    logic [63:0] t;
    int unsigned amp;
    int unsigned nv;
    int unsigned nf;
    int unsigned j;
    int unsigned r;
    in_word_t w;
    t = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: write_threshold(mvw_pkg::WeldDistSqRst);
      1: write_threshold('0);
      2: write_threshold(DistMax);
      3: write_threshold(DistW'(1));
      4: write_threshold(DistW'(1) << $urandom_range(1, 20));
      5: write_threshold(DistW'(1) << $urandom_range(21, 51));
      6: write_threshold(t[DistW-1:0]);
      default: ;
    endcase
    no_idle = ($urandom_range(0, 4) == 0);
    amp = 1 << $urandom_range(0, 12);
    if ($urandom_range(0, 99) < 85 || sent_seen > 700) begin
      send_word(ctl(mvw_pkg::CMD_CLEAR, 1'($urandom_range(0, 1))));
      random_done++;
    end
    nv = $urandom_range(5, 40);
    nf = $urandom_range(3, 20);
    for (int k = 0; k < nv + nf; k++) begin
      // noise: unknown commands and the odd stray face among the vertices
      if ($urandom_range(0, 99) < 4) send_word(ctl(CmdUnknown, 1'($urandom_range(0, 1))));
      if (k < nv) begin
        r = $urandom_range(0, 99);
        j = (n_sent != 0) ? $urandom_range(0, n_sent - 1) : 0;
        if (n_sent != 0 && r < 45)
          w = vtx(nudge(px[j], amp), nudge(py[j], amp), nudge(pz[j], amp), k == nv - 1);
        else if (n_sent != 0 && r < 60)
          w = vtx(px[j], py[j], pz[j], k == nv - 1);
        else if (r < 75)
          w = vtx(nudge('0, 64), nudge('0, 64), nudge('0, 64), k == nv - 1);
        else
          w = vtx(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), k == nv - 1);
        if ($urandom_range(0, 99) < 2)
          w = face(pick_corner(), pick_corner(), pick_corner(), 1'b0);
      end else begin
        w = face(pick_corner(), pick_corner(), pick_corner(), k == nv + nf - 1);
        // degenerate by construction
        r = $urandom_range(0, 99);
        if (r < 12) w.corner_c = w.corner_a;
        else if (r < 24) w.corner_b = w.corner_a;
      end
      send_word(w);
      random_done++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    no_idle = 1'b0;
    sent_seen = 0;
    n_sent = 0;
    random_done = 0;
    tracker = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset threshold of 17
    send_word(face(10'd0, 10'd0, 10'd0, 1'b0));                 // corner before any vertex
    send_word(vtx(CoordMin, CoordMax, '0, 1'b0));
    send_word(vtx(CoordMin, CoordMax, '0, 1'b0));               // exact repeat welds
    send_word(vtx(CoordMin + 24'sd4, CoordMax, '0, 1'b0));      // squared distance 16, welds
    send_word(vtx(CoordMin + 24'sd4, CoordMax, 24'sd1, 1'b0));  // squared distance 17, not below, new
    send_word(vtx(CoordMax, CoordMin, CoordMin, 1'b0));
    send_word(vtx('0, '0, '0, 1'b1));
    send_word(face(10'd0, 10'd4, 10'd5, 1'b0));                 // all distinct
    send_word(face(10'd1, 10'd2, 10'd3, 1'b0));                 // two of three collapse to one
    send_word(face(10'd4, 10'd5, 10'd4, 1'b0));                 // two corners equal
    send_word(face(10'd5, 10'd6, 10'd1023, 1'b1));              // past the seen count
    send_word(ctl(CmdUnknown, 1'b1));
    send_word(ctl(mvw_pkg::CMD_CLEAR, 1'b0));
    send_word(face(10'd0, 10'd1, 10'd2, 1'b0));                 // everything unknown after clear
    // zero threshold: nothing ever welds
    write_threshold('0);
    send_word(vtx(24'sd5, 24'sd5, 24'sd5, 1'b0));
    send_word(vtx(24'sd5, 24'sd5, 24'sd5, 1'b0));
    send_word(face(10'd0, 10'd1, 10'd0, 1'b1));
    // full threshold: every vertex welds to the first
    write_threshold(DistMax);
    send_word(ctl(mvw_pkg::CMD_CLEAR, 1'b1));
    send_word(vtx(CoordMax, CoordMax, CoordMax, 1'b0));
    send_word(vtx(CoordMin, CoordMin, CoordMin, 1'b1));
    send_word(face(10'd0, 10'd1, 10'd1, 1'b0));

    while (random_done < RandomItems) run_phase();

    // deeper store: distinct vertices, exact repeats, then faces across it
    no_idle = 1'b0;
    write_threshold(DistW'(1));
    send_word(ctl(mvw_pkg::CMD_CLEAR, 1'b0));
    for (int k = 0; k < FreshFill; k++)
      send_word(vtx(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), 1'b0));
    while (sent_seen < FillTarget) begin
      int unsigned j;
      j = $urandom_range(0, FreshFill - 1);
      send_word(vtx(px[j], py[j], pz[j], 1'b0));
    end
    for (int k = 0; k < 3; k++)
      send_word(vtx(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom), k == 2));
    for (int k = 0; k < 12; k++)
      send_word(face(IndexW'($urandom_range(0, FillTarget + 7)),
                     IndexW'($urandom_range(0, FillTarget + 7)),
                     IndexW'($urandom_range(0, FillTarget + 7)), k == 11));
    send_word(face(IndexW'(MaxVerts - 1), 10'd0, IndexW'(MaxVerts - 1), 1'b1));

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (tracker.fail_count == 0 && tracker.due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
